@@ rtl/core/tga_rle_pixel_decoder_defines.svh @@
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_defines
// assertion macros used by the decoder result back end (tgarle_back)
// ----------------------------------------------------------------------------
`ifndef TGA_RLE_PIXEL_DECODER_DEFINES_SVH
`define TGA_RLE_PIXEL_DECODER_DEFINES_SVH

// same-cycle implication
`define TGARLE_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tgarle: assertion failed");

// next-cycle implication
`define TGARLE_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tgarle: assertion failed");

`endif

@@ rtl/core/tgarle_pkg.sv @@
// ----------------------------------------------------------------------------
// tgarle_pkg
// types, constants and helpers for the run-length pixel decoder
// ----------------------------------------------------------------------------
package tgarle_pkg;

    localparam int LANES           = 4;
    localparam int MAX_PIXEL_BYTES = 4;
    localparam int LANE_PORTS      = 4;
    localparam int ACTIVE_LANES    = (LANES < 1) ? 1 :
                                     ((LANES > LANE_PORTS) ? LANE_PORTS : LANES);

    localparam int PIXEL_W  = 32;
    localparam int COUNT_W  = 3;
    localparam int LEFT_W   = 8;
    localparam int BIDX_W   = 2;
    localparam int SIZE_W   = 3;
    localparam int DEPTH_W  = 8;
    localparam int FRAME_W  = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_DEPTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIXELS = CFG_IDX_W'(1);

    localparam logic [DEPTH_W-1:0] DEPTH_RESET  = DEPTH_W'(32);
    localparam logic [FRAME_W-1:0] FRAME_RESET  = FRAME_W'(1);

    localparam logic [DEPTH_W-1:0] DEPTH_GREY   = DEPTH_W'(8);
    localparam logic [DEPTH_W-1:0] DEPTH_HI15   = DEPTH_W'(15);
    localparam logic [DEPTH_W-1:0] DEPTH_HI16   = DEPTH_W'(16);
    localparam logic [DEPTH_W-1:0] DEPTH_TRUE24 = DEPTH_W'(24);
    localparam logic [DEPTH_W-1:0] DEPTH_TRUE32 = DEPTH_W'(32);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LONG  = 2'd1,
        ST_BAD_DEPTH = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CMD_BAD_DEPTH = 2'd0,
        CMD_TOO_LONG  = 2'd1,
        CMD_RAW       = 2'd2,
        CMD_RUN       = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [PIXEL_W-1:0]  pixel;
        logic [LEFT_W-1:0]   count;
    } cmd_t;

    typedef struct packed {
        logic                busy;
        logic [FRAME_W-1:0]  pixels_done;
    } back_stat_t;

    function automatic logic [SIZE_W-1:0] bytes_per_pixel(input logic [DEPTH_W-1:0] depth);
        logic [SIZE_W-1:0] n;
        unique case (depth) inside
            DEPTH_GREY:             n = SIZE_W'(1);
            DEPTH_HI15, DEPTH_HI16: n = SIZE_W'(2);
            DEPTH_TRUE24:           n = SIZE_W'(3);
            DEPTH_TRUE32:           n = SIZE_W'(4);
            default:                n = '0;
        endcase
        if (int'(n) > MAX_PIXEL_BYTES)
        begin
            n = '0;
        end
        return n;
    endfunction

endpackage

@@ rtl/core/tgarle_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// tgarle_cmd_fifo
// short command queue between the byte front end and the result back end
// ----------------------------------------------------------------------------
module tgarle_cmd_fifo
    import tgarle_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop,
    output cmd_t pop_cmd
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    always_comb
    begin
        push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
        pop_valid  = (count_reg != '0);
        pop_cmd    = entry_reg[rd_ptr_reg];
        do_push    = push_valid && push_ready;
        do_pop     = pop && pop_valid;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/core/tgarle_front.sv @@
// ----------------------------------------------------------------------------
// tgarle_front
// takes stream bytes, parses packet headers and gathers pixel bytes
// ----------------------------------------------------------------------------
module tgarle_front
    import tgarle_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic [DEPTH_W-1:0] pixel_depth,
    input  logic [FRAME_W-1:0] frame_pixels,
    input  back_stat_t         back_stat,
    input  logic               q_valid,
    input  logic               q_ready,
    output logic               enq_valid,
    output cmd_t               enq_cmd
);

    typedef enum logic [1:0] {
        PH_HEADER = 2'b01,
        PH_PIXEL  = 2'b10
    } phase_t;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic               repeat_reg;
    logic               repeat_next;
    logic [LEFT_W-1:0]  left_reg;
    logic [LEFT_W-1:0]  left_next;
    logic [BIDX_W-1:0]  bidx_reg;
    logic [BIDX_W-1:0]  bidx_next;
    logic [PIXEL_W-1:0] gather_reg;
    logic [PIXEL_W-1:0] gather_next;

    logic [SIZE_W-1:0]  size;
    logic               depth_bad;
    logic               drained;
    logic [LEFT_W-1:0]  hdr_count;
    logic               too_long;
    logic [PIXEL_W-1:0] shifted;
    logic [PIXEL_W-1:0] gathered;
    logic               complete;
    logic [LEFT_W-1:0]  left_dec;
    logic               fire;

    always_comb
    begin
        size      = bytes_per_pixel(pixel_depth);
        depth_bad = (size == '0);
        drained   = !q_valid && !back_stat.busy;
        hdr_count = {1'b0, data_byte[6:0]} + LEFT_W'(1);
        too_long  = ({1'b0, back_stat.pixels_done} + (FRAME_W + 1)'(hdr_count))
                    > {1'b0, frame_pixels};
        case (bidx_reg)
            2'd0:    shifted = {24'd0, data_byte};
            2'd1:    shifted = {16'd0, data_byte, 8'd0};
            2'd2:    shifted = {8'd0, data_byte, 16'd0};
            default: shifted = {data_byte, 24'd0};
        endcase
        gathered = gather_reg | shifted;
        complete = ({1'b0, bidx_reg} + SIZE_W'(1)) >= size;
        left_dec = left_reg - LEFT_W'(1);

        in_ready = q_ready && (depth_bad || (phase_reg == PH_PIXEL) || drained);
        fire     = in_valid && in_ready;

        phase_next  = phase_reg;
        repeat_next = repeat_reg;
        left_next   = left_reg;
        bidx_next   = bidx_reg;
        gather_next = gather_reg;
        enq_valid   = 1'b0;
        enq_cmd     = '{kind: CMD_RAW, pixel: gathered, count: left_reg};

        if (fire)
        begin
            if (depth_bad)
            begin
                enq_valid    = 1'b1;
                enq_cmd.kind = CMD_BAD_DEPTH;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        if (too_long)
                        begin
                            enq_valid    = 1'b1;
                            enq_cmd.kind = CMD_TOO_LONG;
                        end
                        else
                        begin
                            left_next   = hdr_count;
                            repeat_next = data_byte[7];
                            bidx_next   = '0;
                            gather_next = '0;
                            phase_next  = PH_PIXEL;
                        end
                    end
                    PH_PIXEL:
                    begin
                        if (!complete)
                        begin
                            bidx_next   = bidx_reg + 1'b1;
                            gather_next = gathered;
                        end
                        else
                        begin
                            bidx_next   = '0;
                            gather_next = '0;
                            enq_valid   = 1'b1;
                            if (!repeat_reg)
                            begin
                                enq_cmd.kind = CMD_RAW;
                                left_next    = left_dec;
                                if (left_dec == '0)
                                begin
                                    phase_next = PH_HEADER;
                                end
                            end
                            else
                            begin
                                enq_cmd.kind = CMD_RUN;
                                left_next    = '0;
                                phase_next   = PH_HEADER;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HEADER;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            repeat_reg <= 1'b0;
            left_reg   <= '0;
            bidx_reg   <= '0;
            gather_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            repeat_reg <= repeat_next;
            left_reg   <= left_next;
            bidx_reg   <= bidx_next;
            gather_reg <= gather_next;
        end
    end

endmodule

@@ rtl/core/tgarle_back.sv @@
// ----------------------------------------------------------------------------
// tgarle_back
// executes queued commands, counts frame pixels and holds the result beat
// ----------------------------------------------------------------------------
`include "tga_rle_pixel_decoder_defines.svh"

module tgarle_back
    import tgarle_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  cmd_t               q_cmd,
    output logic               q_pop,
    input  logic [FRAME_W-1:0] frame_pixels,
    output back_stat_t         back_stat,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [PIXEL_W-1:0] pixel_a,
    output logic [PIXEL_W-1:0] pixel_b,
    output logic [PIXEL_W-1:0] pixel_c,
    output logic [PIXEL_W-1:0] pixel_d,
    output logic [COUNT_W-1:0] pixel_count,
    output logic               run_end,
    output logic               frame_done,
    output logic [1:0]         status
);

    logic               busy_reg;
    cmd_kind_t          kind_reg;
    logic [PIXEL_W-1:0] pixel_reg;
    logic [LEFT_W-1:0]  left_reg;
    logic [FRAME_W-1:0] pd_reg;
    logic [FRAME_W-1:0] pd_next;

    logic               out_valid_reg;
    logic [PIXEL_W-1:0] out_lane_reg [LANE_PORTS];
    logic [PIXEL_W-1:0] lane_next [LANE_PORTS];
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_run_end_reg;
    logic               out_done_reg;
    status_t            out_status_reg;
    status_t            status_next;

    logic               can_emit;
    logic               emit;
    logic               is_pixel;
    logic [COUNT_W-1:0] n;
    logic               last;
    logic [FRAME_W:0]   sum;
    logic               hit;

    always_comb
    begin
        can_emit = !out_valid_reg || out_ready;
        emit     = busy_reg && can_emit;
        is_pixel = (kind_reg == CMD_RAW) || (kind_reg == CMD_RUN);

        case (kind_reg)
            CMD_RUN:
            begin
                n    = (left_reg > LEFT_W'(ACTIVE_LANES)) ? COUNT_W'(ACTIVE_LANES)
                                                          : left_reg[COUNT_W-1:0];
                last = (left_reg <= LEFT_W'(ACTIVE_LANES));
            end
            CMD_RAW:
            begin
                n    = COUNT_W'(1);
                last = 1'b1;
            end
            default:
            begin
                n    = '0;
                last = 1'b1;
            end
        endcase

        sum = {1'b0, pd_reg} + (FRAME_W + 1)'(n);
        hit = sum >= {1'b0, frame_pixels};

        case (kind_reg)
            CMD_BAD_DEPTH: status_next = ST_BAD_DEPTH;
            CMD_TOO_LONG:  status_next = ST_TOO_LONG;
            default:       status_next = ST_OK;
        endcase

        pd_next = pd_reg;
        if (kind_reg == CMD_TOO_LONG)
        begin
            pd_next = '0;
        end
        else if (is_pixel)
        begin
            pd_next = hit ? '0 : sum[FRAME_W-1:0];
        end

        for (int i = 0; i < LANE_PORTS; i++)
        begin
            lane_next[i] = (is_pixel && (i < int'(n))) ? pixel_reg : '0;
        end

        q_pop = q_valid && (!busy_reg || (emit && last));

        back_stat.busy        = busy_reg;
        back_stat.pixels_done = pd_reg;

        out_valid   = out_valid_reg;
        pixel_a     = out_lane_reg[0];
        pixel_b     = out_lane_reg[1];
        pixel_c     = out_lane_reg[2];
        pixel_d     = out_lane_reg[3];
        pixel_count = out_count_reg;
        run_end     = out_run_end_reg;
        frame_done  = out_done_reg;
        status      = out_status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            kind_reg      <= CMD_RAW;
            left_reg      <= '0;
            pd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                busy_reg <= 1'b1;
                kind_reg <= q_cmd.kind;
                left_reg <= q_cmd.count;
            end
            else if (emit && last)
            begin
                busy_reg <= 1'b0;
            end
            else if (emit)
            begin
                left_reg <= left_reg - LEFT_W'(n);
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
                pd_reg        <= pd_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            pixel_reg <= q_cmd.pixel;
        end
        if (emit)
        begin
            out_lane_reg    <= lane_next;
            out_count_reg   <= n;
            out_run_end_reg <= last;
            out_done_reg    <= is_pixel && hit;
            out_status_reg  <= status_next;
        end
    end

    // error beats carry no pixels and close the byte
    `TGARLE_ASSERT_IMPL(a_err_beat_empty, out_valid_reg && (out_status_reg != ST_OK), (out_count_reg == '0) && out_run_end_reg && !out_done_reg)
    // an active run always has pixels left
    `TGARLE_ASSERT_IMPL(a_run_has_left, busy_reg && (kind_reg == CMD_RUN), left_reg != '0)
    // a run that is not on its last beat keeps going
    `TGARLE_ASSERT_NEXT(a_run_continues, emit && !last, busy_reg && (kind_reg == CMD_RUN))
    // frame completion restarts the pixel count
    `TGARLE_ASSERT_NEXT(a_frame_restart, emit && is_pixel && hit, pd_reg == '0)

endmodule

@@ rtl/core/tga_rle_pixel_decoder.sv @@
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// run-length pixel stream decoder, one compressed byte per beat
// ----------------------------------------------------------------------------
// input channel in_valid/in_ready carries data_byte; output channel
// out_valid/out_ready carries up to four pixel lanes, pixel_count, run_end,
// frame_done and status. cfg_valid/cfg_ready writes pixel_depth (index 0)
// and frame_pixels (index 1); cfg_ready is always high.
// a byte that completes a pixel, or an error byte, passes the command queue
// and command register to the output register. raw pixels give one beat
// each; a repeat packet gives ceil(count/4) beats at one per unstalled cycle.
// pixel bytes are taken at one per cycle while the two-entry command queue
// has room; a packet header waits until queue and result unit are empty,
// since its length check needs the final pixel count of the frame.
// reset returns the parser to expect a header, clears the pixel count and
// sets pixel_depth to 32 and frame_pixels to 1. a stalled output holds its
// beat; the queue keeps taking bytes until it fills, then in_ready drops.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder
    import tgarle_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            data_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIXEL_W-1:0]    pixel_a,
    output logic [PIXEL_W-1:0]    pixel_b,
    output logic [PIXEL_W-1:0]    pixel_c,
    output logic [PIXEL_W-1:0]    pixel_d,
    output logic [COUNT_W-1:0]    pixel_count,
    output logic                  run_end,
    output logic                  frame_done,
    output logic [1:0]            status,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [DEPTH_W-1:0] depth_reg;
    logic [FRAME_W-1:0] frame_reg;

    back_stat_t back_stat;
    logic       enq_valid;
    cmd_t       enq_cmd;
    logic       q_ready;
    logic       q_valid;
    cmd_t       q_cmd;
    logic       q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= DEPTH_RESET;
            frame_reg <= FRAME_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PIXEL_DEPTH:  depth_reg <= cfg_data[DEPTH_W-1:0];
                REG_FRAME_PIXELS: frame_reg <= cfg_data[FRAME_W-1:0];
                default:          ;
            endcase
        end
    end

    tgarle_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .pixel_depth  (depth_reg),
        .frame_pixels (frame_reg),
        .back_stat    (back_stat),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .enq_valid    (enq_valid),
        .enq_cmd      (enq_cmd)
    );

    tgarle_cmd_fifo u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (enq_valid),
        .push_ready (q_ready),
        .push_cmd   (enq_cmd),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_cmd    (q_cmd)
    );

    tgarle_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .frame_pixels (frame_reg),
        .back_stat    (back_stat),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_a      (pixel_a),
        .pixel_b      (pixel_b),
        .pixel_c      (pixel_c),
        .pixel_d      (pixel_d),
        .pixel_count  (pixel_count),
        .run_end      (run_end),
        .frame_done   (frame_done),
        .status       (status)
    );

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the run-length tga pixel decoder
// ----------------------------------------------------------------------------
// a short scripted sequence covers reset values, field extremes, every depth,
// bad depths, packets that overrun the frame, an empty frame size and depth
// or frame size changes part way through a pixel or packet. random packets
// with random content follow, over several register settings and idling
// modes, including one long output hold-off. every output beat is checked
// field by field against a scripted beat or against a behavioural decoder
// model kept in step with the accepted bytes.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tgarle_pkg::*;

    localparam int RANDOM_ITEMS     = 420;
    localparam int SEGMENT_ITEMS    = 40;
    localparam int SETTLE_CYCLES    = 10;
    localparam int DRAIN_CYCLES     = 20;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int PRESSURE_SEGMENT = 4;
    localparam int QUIET_LIMIT      = 3000;
    localparam int REPORT_LINES     = 40;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

    typedef struct packed {
        logic [PIXEL_W-1:0] pa;
        logic [PIXEL_W-1:0] pb;
        logic [PIXEL_W-1:0] pc;
        logic [PIXEL_W-1:0] pd;
        logic [COUNT_W-1:0] count;
        logic               run_end;
        logic               frame_done;
        status_t            status;
    } pix_beat_t;

    typedef enum logic {
        ROW_BYTE = 1'b0,
        ROW_REG  = 1'b1
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
        logic                  typed;
        pix_beat_t             beat;
    } row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [7:0]            data_byte;
    logic                  out_valid;
    logic                  out_ready;
    logic [PIXEL_W-1:0]    pixel_a;
    logic [PIXEL_W-1:0]    pixel_b;
    logic [PIXEL_W-1:0]    pixel_c;
    logic [PIXEL_W-1:0]    pixel_d;
    logic [COUNT_W-1:0]    pixel_count;
    logic                  run_end;
    logic                  frame_done;
    logic [1:0]            status;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // decoder model state
    logic [DEPTH_W-1:0]    cfg_depth;
    logic [FRAME_W-1:0]    cfg_frame;
    logic                  mid_packet;
    logic                  run_repeat;
    logic [LEFT_W-1:0]     run_left;
    logic [BIDX_W-1:0]     gather_index;
    logic [PIXEL_W-1:0]    gather_word;
    logic [FRAME_W-1:0]    frame_fill;

    pix_beat_t             fresh_beats [$];
    pix_beat_t             expected_beats [$];
    row_t                  script [$];

    int                    mismatch_count = 0;
    int                    quiet_cycles = 0;
    int                    items_sent = 0;
    int                    idle_pct = 0;
    int                    stall_pct = 0;
    bit                    hold_off_req = 1'b0;

    tga_rle_pixel_decoder dut (.*);

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int unsigned depth_bytes(input logic [DEPTH_W-1:0] depth);
        int unsigned n;
        case (depth)
            DEPTH_GREY:             n = 1;
            DEPTH_HI15, DEPTH_HI16: n = 2;
            DEPTH_TRUE24:           n = 3;
            DEPTH_TRUE32:           n = 4;
            default:                n = 0;
        endcase
        if (n > MAX_PIXEL_BYTES)
        begin
            n = 0;
        end
        return n;
    endfunction

    function automatic logic tally_frame(input int unsigned n);
        logic [FRAME_W:0] sum;
        sum = {1'b0, frame_fill} + (FRAME_W + 1)'(n);
        if (sum >= {1'b0, cfg_frame})
        begin
            frame_fill = '0;
            return 1'b1;
        end
        frame_fill = sum[FRAME_W-1:0];
        return 1'b0;
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        int unsigned size;
        int unsigned count;
        int unsigned left;
        int unsigned n;
        pix_beat_t   beat;
        fresh_beats.delete();
        size = depth_bytes(cfg_depth);
        beat = '0;
        beat.status = ST_OK;
        if (size == 0)
        begin
            beat.run_end = 1'b1;
            beat.status = ST_BAD_DEPTH;
            fresh_beats.push_back(beat);
            return;
        end
        if (!mid_packet)
        begin
            count = b[6:0] + 1;
            if (64'(frame_fill) + count > 64'(cfg_frame))
            begin
                frame_fill = '0;
                beat.run_end = 1'b1;
                beat.status = ST_TOO_LONG;
                fresh_beats.push_back(beat);
                return;
            end
            run_left = LEFT_W'(count);
            run_repeat = b[7];
            gather_index = '0;
            gather_word = '0;
            mid_packet = 1'b1;
            return;
        end
        gather_word = gather_word | (PIXEL_W'(b) << (8 * gather_index));
        // a pixel closes once the index plus one reaches or passes the current size
        if (gather_index + 1 < size)
        begin
            gather_index = gather_index + 1'b1;
            return;
        end
        gather_index = '0;
        if (!run_repeat)
        begin
            beat.pa = gather_word;
            beat.count = COUNT_W'(1);
            beat.run_end = 1'b1;
            beat.frame_done = tally_frame(1);
            fresh_beats.push_back(beat);
            gather_word = '0;
            run_left = run_left - 1'b1;
            if (run_left == 0)
            begin
                mid_packet = 1'b0;
            end
        end
        else
        begin
            left = int'(run_left);
            while (left > 0)
            begin
                n = (left < ACTIVE_LANES) ? left : ACTIVE_LANES;
                left = left - n;
                beat.pa = gather_word;
                beat.pb = (n > 1) ? gather_word : '0;
                beat.pc = (n > 2) ? gather_word : '0;
                beat.pd = (n > 3) ? gather_word : '0;
                beat.count = COUNT_W'(n);
                beat.run_end = (left == 0);
                beat.frame_done = tally_frame(n);
                fresh_beats.push_back(beat);
            end
            run_left = '0;
            gather_word = '0;
            mid_packet = 1'b0;
        end
    endfunction

    function automatic pix_beat_t ok_beat(input logic [PIXEL_W-1:0] px,
                                          input logic [COUNT_W-1:0] cnt,
                                          input logic done);
        pix_beat_t beat;
        beat = '0;
        beat.pa = px;
        beat.pb = (cnt > 1) ? px : '0;
        beat.pc = (cnt > 2) ? px : '0;
        beat.pd = (cnt > 3) ? px : '0;
        beat.count = cnt;
        beat.run_end = 1'b1;
        beat.frame_done = done;
        beat.status = ST_OK;
        return beat;
    endfunction

    function automatic pix_beat_t err_beat(input status_t st);
        pix_beat_t beat;
        beat = '0;
        beat.run_end = 1'b1;
        beat.status = st;
        return beat;
    endfunction

    function automatic row_t byte_row(input logic [7:0] b);
        row_t r;
        r = '0;
        r.kind = ROW_BYTE;
        r.value = CFG_DATA_W'(b);
        return r;
    endfunction

    function automatic row_t typed_row(input logic [7:0] b, input pix_beat_t beat);
        row_t r;
        r = byte_row(b);
        r.typed = 1'b1;
        r.beat = beat;
        return r;
    endfunction

    function automatic row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] val);
        row_t r;
        r = '0;
        r.kind = ROW_REG;
        r.index = idx;
        r.value = val;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < REPORT_LINES)
        begin
            $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        end
        mismatch_count++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic typed, input pix_beat_t beat);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        decode_byte(b);
        if (typed)
        begin
            expected_beats.push_back(beat);
        end
        else
        begin
            foreach (fresh_beats[i])
            begin
                expected_beats.push_back(fresh_beats[i]);
            end
        end
        items_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
        begin
            @(negedge clk);
        end
        // bytes with no beat of their own may still be in flight
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_PIXEL_DEPTH)
        begin
            cfg_depth = val[DEPTH_W-1:0];
        end
        else if (idx == REG_FRAME_PIXELS)
        begin
            cfg_frame = val;
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_packet();
        logic [7:0]  hdr;
        int unsigned size;
        int unsigned body;
        // finish any packet left open by noise
        while (mid_packet)
        begin
            send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        end
        if ($urandom_range(0, 9) == 0)
        begin
            send_byte(8'h80 | 8'($urandom_range(0, 255)), 1'b0, '0);
        end
        size = depth_bytes(cfg_depth);
        if ($urandom_range(0, 1) == 1)
        begin
            hdr = {1'b1, 7'($urandom_range(0, 127))};
        end
        else if (size == 1 && $urandom_range(0, 3) == 0)
        begin
            hdr = {1'b0, 7'($urandom_range(0, 127))};
        end
        else
        begin
            hdr = {1'b0, 7'($urandom_range(0, 15))};
        end
        send_byte(hdr, 1'b0, '0);
        if (mid_packet)
        begin
            body = hdr[7] ? size : size * (hdr[6:0] + 1);
            repeat (body) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin : beat_check
        pix_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_beats.size() == 0)
            begin
                report_mismatch("unexpected beat, pixel_a", pixel_a, '0);
            end
            else
            begin
                want = expected_beats.pop_front();
                if (pixel_a !== want.pa)
                    report_mismatch("pixel_a", pixel_a, want.pa);
                if (pixel_b !== want.pb)
                    report_mismatch("pixel_b", pixel_b, want.pb);
                if (pixel_c !== want.pc)
                    report_mismatch("pixel_c", pixel_c, want.pc);
                if (pixel_d !== want.pd)
                    report_mismatch("pixel_d", pixel_d, want.pd);
                if (pixel_count !== want.count)
                    report_mismatch("pixel_count", 32'(pixel_count), 32'(want.count));
                if (run_end !== want.run_end)
                    report_mismatch("run_end", 32'(run_end), 32'(want.run_end));
                if (frame_done !== want.frame_done)
                    report_mismatch("frame_done", 32'(frame_done), 32'(want.frame_done));
                if (status !== want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout with %0d beats outstanding", expected_beats.size());
                $display("FAIL tga_rle_pixel_decoder");
                $finish;
            end
        end
    end

    initial
    begin : receiver
        int held;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                held = 0;
                while (held < HOLD_OFF_CYCLES)
                begin
                    out_ready <= 1'b0;
                    held++;
                    @(negedge clk);
                end
            end
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial
    begin : stimulus
        int unsigned        seg;
        int                 seg_end;
        logic [DEPTH_W-1:0] depth;
        logic [FRAME_W-1:0] frame;
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cfg_depth = DEPTH_RESET;
        cfg_frame = FRAME_RESET;
        mid_packet = 1'b0;
        run_repeat = 1'b0;
        run_left = '0;
        gather_index = '0;
        gather_word = '0;
        frame_fill = '0;

        script = '{
            reg_row(REG_SPARE, 32'h0000_0008),
            byte_row(8'h00),
            byte_row(8'h78),
            byte_row(8'h56),
            byte_row(8'h34),
            typed_row(8'h12, ok_beat(32'h1234_5678, COUNT_W'(1), 1'b1)),
            typed_row(8'h01, err_beat(ST_TOO_LONG)),
            typed_row(8'hff, err_beat(ST_TOO_LONG)),
            reg_row(REG_PIXEL_DEPTH, CFG_DATA_W'(DEPTH_GREY)),
            reg_row(REG_FRAME_PIXELS, 32'd1000),
            byte_row(8'h83),
            typed_row(8'hab, ok_beat(32'h0000_00ab, COUNT_W'(4), 1'b0)),
            byte_row(8'hff),
            byte_row(8'hff),
            byte_row(8'h01),
            byte_row(8'h00),
            reg_row(REG_PIXEL_DEPTH, 32'd7),
            typed_row(8'h55, err_beat(ST_BAD_DEPTH)),
            reg_row(REG_PIXEL_DEPTH, 32'hffff_ffff),
            typed_row(8'h00, err_beat(ST_BAD_DEPTH)),
            reg_row(REG_PIXEL_DEPTH, 32'd0),
            typed_row(8'haa, err_beat(ST_BAD_DEPTH)),
            reg_row(REG_PIXEL_DEPTH, CFG_DATA_W'(DEPTH_HI15)),
            byte_row(8'hff),
            reg_row(REG_PIXEL_DEPTH, CFG_DATA_W'(DEPTH_TRUE24)),
            byte_row(8'h80),
            reg_row(REG_PIXEL_DEPTH, CFG_DATA_W'(DEPTH_HI16)),
            byte_row(8'h7e),
            reg_row(REG_FRAME_PIXELS, 32'd0),
            typed_row(8'h80, err_beat(ST_TOO_LONG)),
            reg_row(REG_FRAME_PIXELS, 32'd10),
            reg_row(REG_PIXEL_DEPTH, CFG_DATA_W'(DEPTH_TRUE32)),
            byte_row(8'h87),
            reg_row(REG_FRAME_PIXELS, 32'd3),
            byte_row(8'h01),
            byte_row(8'h02),
            byte_row(8'h03),
            byte_row(8'h04),
            reg_row(REG_FRAME_PIXELS, 32'hffff_ffff)
        };

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (script[i])
        begin
            if (script[i].kind == ROW_REG)
                write_reg(script[i].index, script[i].value);
            else
                send_byte(script[i].value[7:0], script[i].typed, script[i].beat);
        end

        items_sent = 0;
        seg = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            case (seg % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 82; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 82; end
                default: begin idle_pct = 9;  stall_pct = 9;  end
            endcase
            if ($urandom_range(0, 7) == 0)
            begin
                do
                    depth = DEPTH_W'($urandom_range(0, 255));
                while (depth_bytes(depth) != 0);
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0:       depth = DEPTH_GREY;
                    1:       depth = DEPTH_HI15;
                    2:       depth = DEPTH_HI16;
                    3:       depth = DEPTH_TRUE24;
                    default: depth = DEPTH_TRUE32;
                endcase
            end
            case ($urandom_range(0, 9))
                0:       frame = '1;
                1, 2:    frame = FRAME_W'($urandom_range(1, 8));
                default: frame = FRAME_W'($urandom_range(16, 600));
            endcase
            write_reg(REG_PIXEL_DEPTH, {24'($urandom), depth});
            write_reg(REG_FRAME_PIXELS, frame);
            if (seg == PRESSURE_SEGMENT)
            begin
                hold_off_req = 1'b1;
            end
            seg_end = items_sent + SEGMENT_ITEMS;
            if (depth_bytes(depth) == 0)
            begin
                repeat (6) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
            end
            else
            begin
                while (items_sent < seg_end)
                begin
                    send_packet();
                end
            end
            seg++;
        end

        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("PASS tga_rle_pixel_decoder");
        else
            $display("FAIL tga_rle_pixel_decoder");
        $finish;
    end

endmodule
